// ----- sv/tbdsc_pkg.sv -----
// shared types and constants for the trackball button drag and scroll controller
package tbdsc_pkg;

    typedef enum logic [1:0] {
        FUNC_PRESS   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_TICK    = 2'd2,
        FUNC_MOTION  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PRESS   = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_CLICK   = 2'd3
    } t_action;

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_HOLD_TIME   = 2'd0;
    localparam logic [1:0] REG_X_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_Y_THRESHOLD = 2'd2;

    localparam logic [15:0] HOLD_TIME_RST = 16'd2000;
    localparam logic [6:0]  X_THR_RST     = 7'd60;
    localparam logic [6:0]  Y_THR_RST     = 7'd15;
    localparam logic [15:0] HOLD_SAT      = 16'hFFFF;

    typedef struct packed {
        logic [15:0] hold_time_ms;
        logic [6:0]  x_threshold;
        logic [6:0]  y_threshold;
    } t_cfg;

    typedef struct packed {
        t_func             func;
        logic signed [7:0] in_x;
        logic signed [7:0] in_y;
        logic signed [7:0] in_h;
        logic signed [7:0] in_v;
    } t_item;

    typedef struct packed {
        t_action           button_action;
        logic signed [7:0] out_x;
        logic signed [7:0] out_y;
        logic signed [7:0] out_h;
        logic signed [7:0] out_v;
        logic              scroll_active;
    } t_result;

endpackage

// ----- sv/tbdsc_if.sv -----
// valid/ready channel interfaces for input events and result items
interface tbdsc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic signed [7:0] in_x;
    logic signed [7:0] in_y;
    logic signed [7:0] in_h;
    logic signed [7:0] in_v;

    modport source (output valid, func, in_x, in_y, in_h, in_v, input ready);
    modport sink   (input valid, func, in_x, in_y, in_h, in_v, output ready);
endinterface

interface tbdsc_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        button_action;
    logic signed [7:0] out_x;
    logic signed [7:0] out_y;
    logic signed [7:0] out_h;
    logic signed [7:0] out_v;
    logic              scroll_active;

    modport source (output valid, button_action, out_x, out_y, out_h, out_v, scroll_active,
                    input ready);
    modport sink   (input valid, button_action, out_x, out_y, out_h, out_v, scroll_active,
                    output ready);
endinterface

// ----- sv/tbdsc_cfg.sv -----
// apb configuration registers: hold time and scroll thresholds
module tbdsc_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tbdsc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output tbdsc_pkg::t_cfg            o_cfg
);
    import tbdsc_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_time_ms <= HOLD_TIME_RST;
            r_cfg.x_threshold  <= X_THR_RST;
            r_cfg.y_threshold  <= Y_THR_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HOLD_TIME:   r_cfg.hold_time_ms <= pwdata[15:0];
                REG_X_THRESHOLD: r_cfg.x_threshold  <= pwdata[6:0];
                REG_Y_THRESHOLD: r_cfg.y_threshold  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HOLD_TIME:   prdata = {16'd0, r_cfg.hold_time_ms};
            REG_X_THRESHOLD: prdata = {25'd0, r_cfg.x_threshold};
            REG_Y_THRESHOLD: prdata = {25'd0, r_cfg.y_threshold};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ----- sv/tbdsc_core.sv -----
// button mode state and per-event result logic
module tbdsc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  tbdsc_pkg::t_cfg    i_cfg,
    input  tbdsc_pkg::t_item   i_item,
    output tbdsc_pkg::t_result o_res
);
    import tbdsc_pkg::*;

    logic        r_held,  n_held;
    logic        r_moved, n_moved;
    logic        r_drag,  n_drag;
    logic        r_scroll, n_scroll;
    logic [15:0] r_hold,  n_hold;
    logic [7:0]  r_acc_x, n_acc_x;
    logic [7:0]  r_acc_y, n_acc_y;

    logic [15:0]       hold_inc;
    logic [7:0]        sum_x;
    logic [7:0]        sum_y;
    logic signed [8:0] ax;
    logic signed [8:0] ay;
    logic signed [8:0] tx;
    logic signed [8:0] ty;

    assign hold_inc = (r_hold != HOLD_SAT) ? r_hold + 16'd1 : r_hold;
    assign sum_x    = r_acc_x + i_item.in_x;
    assign sum_y    = r_acc_y + i_item.in_y;
    assign ax       = {sum_x[7], sum_x};
    assign ay       = {sum_y[7], sum_y};
    assign tx       = {2'b00, i_cfg.x_threshold};
    assign ty       = {2'b00, i_cfg.y_threshold};

    always_comb begin
        n_held   = r_held;
        n_moved  = r_moved;
        n_drag   = r_drag;
        n_scroll = r_scroll;
        n_hold   = r_hold;
        n_acc_x  = r_acc_x;
        n_acc_y  = r_acc_y;
        o_res.button_action = ACT_NONE;
        o_res.out_x = 8'sd0;
        o_res.out_y = 8'sd0;
        o_res.out_h = 8'sd0;
        o_res.out_v = 8'sd0;
        unique case (i_item.func)
            FUNC_PRESS: begin
                if (r_scroll) begin
                    n_scroll = 1'b0;
                end else begin
                    n_held  = 1'b1;
                    n_hold  = 16'd0;
                    n_moved = 1'b0;
                    n_drag  = 1'b0;
                end
            end
            FUNC_RELEASE: begin
                n_held = 1'b0;
                if (r_drag) begin
                    o_res.button_action = ACT_RELEASE;
                    n_drag = 1'b0;
                end else if (!r_moved && !r_scroll && (r_hold < i_cfg.hold_time_ms)) begin
                    o_res.button_action = ACT_CLICK;
                end
            end
            FUNC_TICK: begin
                n_hold = hold_inc;
                if (r_held && !r_moved && !r_drag && !r_scroll &&
                    (hold_inc > i_cfg.hold_time_ms)) begin
                    n_scroll = 1'b1;
                end
            end
            FUNC_MOTION: begin
                o_res.out_x = i_item.in_x;
                o_res.out_y = i_item.in_y;
                o_res.out_h = i_item.in_h;
                o_res.out_v = i_item.in_v;
                if (r_held && !r_scroll && !r_moved &&
                    ((i_item.in_x != 8'sd0) || (i_item.in_y != 8'sd0))) begin
                    n_moved = 1'b1;
                    n_drag  = 1'b1;
                    o_res.button_action = ACT_PRESS;
                end
                if (r_scroll) begin
                    n_acc_x = sum_x;
                    n_acc_y = sum_y;
                    if (ax > tx) begin
                        o_res.out_h = -8'sd1;
                        n_acc_x = 8'd0;
                    end else if (ax < -tx) begin
                        o_res.out_h = 8'sd1;
                        n_acc_x = 8'd0;
                    end
                    if (ay > ty) begin
                        o_res.out_v = 8'sd1;
                        n_acc_y = 8'd0;
                    end else if (ay < -ty) begin
                        o_res.out_v = -8'sd1;
                        n_acc_y = 8'd0;
                    end
                    o_res.out_x = 8'sd0;
                    o_res.out_y = 8'sd0;
                end
            end
        endcase
        o_res.scroll_active = n_scroll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 1'b0;
            r_moved  <= 1'b0;
            r_drag   <= 1'b0;
            r_scroll <= 1'b0;
            r_hold   <= HOLD_SAT;
            r_acc_x  <= 8'd0;
            r_acc_y  <= 8'd0;
        end else if (i_en) begin
            r_held   <= n_held;
            r_moved  <= n_moved;
            r_drag   <= n_drag;
            r_scroll <= n_scroll;
            r_hold   <= n_hold;
            r_acc_x  <= n_acc_x;
            r_acc_y  <= n_acc_y;
        end
    end

endmodule

// ----- sv/trackball_button_drag_scroll_ctrl.sv -----
// top level: input register, mode logic, result register and config port
//
// events (press, release, millisecond tick, motion report) enter on i_in, a
// valid/ready channel; every event gives exactly one result item on o_out
// with the button action, pointer motion, scroll steps and scroll mode flag.
// registers (hold time, x and y thresholds) are written over the apb port at
// byte addresses 0, 4 and 8 and read back there; pready is always high.
// an event lands in the input register when accepted, passes the mode logic
// and is loaded into the result register once that is empty or being read.
// one event per cycle is sustained while o_out.ready stays high, set by the
// single pass from the input register through the mode logic into the result
// register. when the receiver holds o_out.ready low the result register keeps
// its item, the input register still takes one more event if it is empty,
// and only then does i_in.ready drop; nothing is lost or repeated.
// a synchronous reset empties both registers, restores the register defaults
// and returns the mode state to idle with the hold counter saturated.
module trackball_button_drag_scroll_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tbdsc_in_if.sink                     i_in,
    tbdsc_out_if.source                  o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tbdsc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tbdsc_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    t_result res;
    t_result r_res;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;

    assign advance     = r_in_valid & (~r_out_valid | o_out.ready);
    assign i_in.ready  = ~r_in_valid | advance;

    tbdsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tbdsc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_cfg   (cfg),
        .i_item  (r_item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.func <= t_func'(i_in.func);
            r_item.in_x <= i_in.in_x;
            r_item.in_y <= i_in.in_y;
            r_item.in_h <= i_in.in_h;
            r_item.in_v <= i_in.in_v;
        end
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.button_action = r_res.button_action;
    assign o_out.out_x         = r_res.out_x;
    assign o_out.out_y         = r_res.out_y;
    assign o_out.out_h         = r_res.out_h;
    assign o_out.out_v         = r_res.out_v;
    assign o_out.scroll_active = r_res.scroll_active;

endmodule

// ----- sim/trackball_button_drag_scroll_ctrl_tb.sv -----
// self-checking testbench for the trackball button drag and scroll controller
`timescale 1ns / 1ps

module trackball_button_drag_scroll_ctrl_tb;
    import tbdsc_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_ITEMS     = 290;
    localparam int NUM_PHASES      = 6;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int HOLDOFF_FIRST   = 500;
    localparam int HOLDOFF_SPACING = 800;
    localparam int DRAIN_CYCLES    = 4;

    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,
        RX_HALF   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_MOSTLY = 2'd3
    } t_rx_mode;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    tbdsc_in_if  in_ch ();
    tbdsc_out_if out_ch ();

    trackball_button_drag_scroll_ctrl dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mode tracker state and register copy
    t_cfg        cfg = '{hold_time_ms: HOLD_TIME_RST, x_threshold: X_THR_RST,
                         y_threshold: Y_THR_RST};
    bit          held      = 1'b0;
    bit          moved     = 1'b0;
    bit          dragging  = 1'b0;
    bit          scrolling = 1'b0;
    logic [15:0] hold_ms   = HOLD_SAT;
    logic [7:0]  acc_x     = '0;
    logic [7:0]  acc_y     = '0;

    t_item   pending_events[$];
    t_result expected_results[$];

    bit      drv_busy   = 1'b0;
    t_item   drv_item   = '0;
    int      burst_left = 1;
    int      gap_left   = 0;
    int      phase_count = 0;

    int       rx_seen      = 0;
    int       holdoff_left = 0;
    int       next_holdoff = HOLDOFF_FIRST;
    int       mode_left    = 0;
    t_rx_mode rx_mode      = RX_OPEN;

    int mismatch_count = 0;
    int cycle_count    = 0;

    int phase_hold[NUM_PHASES] = '{1, 65534, 0, 6, 2000, 0};
    int phase_x[NUM_PHASES]    = '{0, 127, 127, 20, 60, 0};
    int phase_y[NUM_PHASES]    = '{0, 127, 0, 5, 15, 0};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result track_event(input t_item ev);
        t_result r;
        int      ax, ay, tx, ty;
        r = '0;
        r.button_action = ACT_NONE;
        case (ev.func)
            FUNC_PRESS: begin
                if (scrolling) begin
                    scrolling = 1'b0;
                end else begin
                    held     = 1'b1;
                    hold_ms  = '0;
                    moved    = 1'b0;
                    dragging = 1'b0;
                end
            end
            FUNC_RELEASE: begin
                held = 1'b0;
                if (dragging) begin
                    r.button_action = ACT_RELEASE;
                    dragging = 1'b0;
                end else if (!moved && !scrolling && hold_ms < cfg.hold_time_ms) begin
                    r.button_action = ACT_CLICK;
                end
            end
            FUNC_TICK: begin
                if (hold_ms != HOLD_SAT) hold_ms = hold_ms + 16'd1;
                if (held && !moved && !dragging && !scrolling && hold_ms > cfg.hold_time_ms)
                    scrolling = 1'b1;
            end
            default: begin
                r.out_x = ev.in_x;
                r.out_y = ev.in_y;
                r.out_h = ev.in_h;
                r.out_v = ev.in_v;
                if (held && !scrolling && (ev.in_x != 0 || ev.in_y != 0) && !moved) begin
                    moved    = 1'b1;
                    dragging = 1'b1;
                    r.button_action = ACT_PRESS;
                end
                if (scrolling) begin
                    tx = int'(cfg.x_threshold);
                    ty = int'(cfg.y_threshold);
                    acc_x = acc_x + ev.in_x;
                    acc_y = acc_y + ev.in_y;
                    ax = int'($signed(acc_x));
                    ay = int'($signed(acc_y));
                    if (ax > tx) begin
                        r.out_h = -8'sd1;
                        acc_x = '0;
                    end else if (ax < -tx) begin
                        r.out_h = 8'sd1;
                        acc_x = '0;
                    end
                    if (ay > ty) begin
                        r.out_v = 8'sd1;
                        acc_y = '0;
                    end else if (ay < -ty) begin
                        r.out_v = -8'sd1;
                        acc_y = '0;
                    end
                    r.out_x = '0;
                    r.out_y = '0;
                end
            end
        endcase
        r.scroll_active = scrolling;
        return r;
    endfunction

    // sender: bursts of items with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (drv_busy && in_ch.valid && in_ch.ready) begin
                expected_results.push_back(track_event(drv_item));
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_events.size() > 0) begin
                    drv_item = pending_events.pop_front();
                    drv_busy = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            in_ch.valid <= drv_busy;
            in_ch.func  <= drv_item.func;
            in_ch.in_x  <= drv_item.in_x;
            in_ch.in_y  <= drv_item.in_y;
            in_ch.in_h  <= drv_item.in_h;
            in_ch.in_v  <= drv_item.in_v;
        end
    end

    // receiver: random stall pattern plus long hold-offs
    always @(posedge i_clk) begin
        bit rdy;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) rx_seen++;
            if (holdoff_left > 0) begin
                holdoff_left--;
                rdy = 1'b0;
            end else if (rx_seen >= next_holdoff) begin
                holdoff_left = HOLDOFF_CYCLES;
                next_holdoff += HOLDOFF_SPACING;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_HALF:   rdy = 1'($urandom_range(0, 1));
                    RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:   rdy = ($urandom_range(0, 9) != 0);
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual action %h",
                         $time, out_ch.button_action);
                mismatch_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("button_action", 8'(exp_r.button_action),
                            8'(out_ch.button_action));
                check_field("out_x", exp_r.out_x, out_ch.out_x);
                check_field("out_y", exp_r.out_y, out_ch.out_y);
                check_field("out_h", exp_r.out_h, out_ch.out_h);
                check_field("out_v", exp_r.out_v, out_ch.out_v);
                check_field("scroll_active", 8'(exp_r.scroll_active),
                            8'(out_ch.scroll_active));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HOLD_TIME:   cfg.hold_time_ms = value[15:0];
            REG_X_THRESHOLD: cfg.x_threshold  = value[6:0];
            REG_Y_THRESHOLD: cfg.y_threshold  = value[6:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input int hold, input int xthr, input int ythr);
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_X_THRESHOLD, xthr);
        write_reg(REG_Y_THRESHOLD, ythr);
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || drv_busy || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_item(input t_func f, input logic [7:0] x, input logic [7:0] y,
                              input logic [7:0] h, input logic [7:0] v);
        t_item it;
        it.func = f;
        it.in_x = x;
        it.in_y = y;
        it.in_h = h;
        it.in_v = v;
        pending_events.push_back(it);
        phase_count++;
    endtask

    // non-motion events carry random junk in the motion fields
    task automatic queue_ctrl(input t_func f);
        queue_item(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_motion(input logic [7:0] x, input logic [7:0] y);
        queue_item(FUNC_MOTION, x, y, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_delta();
        logic [7:0] d;
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
        d = 8'($urandom_range(0, 32));
        return d - 8'd16;
    endfunction

    task automatic queue_gesture();
        int kind, hold, n;
        hold = int'(cfg.hold_time_ms);
        kind = $urandom_range(0, 99);
        if (kind < 30 && hold > 64) kind = kind + 30;
        if (kind < 30) begin
            // hold still into scroll mode, scroll, then press to leave
            queue_ctrl(FUNC_PRESS);
            if ($urandom_range(0, 3) == 0) queue_motion(8'd0, 8'd0);
            n = hold + $urandom_range(0, 3);
            repeat (n) queue_ctrl(FUNC_TICK);
            if ($urandom_range(0, 1)) queue_ctrl(FUNC_RELEASE);
            repeat ($urandom_range(2, 12)) queue_motion(pick_delta(), pick_delta());
            queue_ctrl(FUNC_PRESS);
            if ($urandom_range(0, 1)) queue_ctrl(FUNC_RELEASE);
        end else if (kind < 60) begin
            queue_ctrl(FUNC_PRESS);
            repeat ($urandom_range(0, 3)) queue_ctrl(FUNC_TICK);
            if ($urandom_range(0, 3) == 0) queue_motion(8'd0, 8'd0);
            repeat ($urandom_range(1, 6)) queue_motion(pick_delta(), pick_delta());
            if ($urandom_range(0, 3) == 0) queue_ctrl(FUNC_PRESS);
            queue_ctrl(FUNC_RELEASE);
        end else if (kind < 85) begin
            queue_ctrl(FUNC_PRESS);
            n = (hold <= 8) ? $urandom_range(0, hold + 2) : $urandom_range(0, 6);
            repeat (n) queue_ctrl(FUNC_TICK);
            if ($urandom_range(0, 2) == 0) queue_motion(8'd0, 8'd0);
            queue_ctrl(FUNC_RELEASE);
        end else begin
            repeat ($urandom_range(1, 4))
                queue_item(t_func'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int ph;
        in_ch.valid  = 1'b0;
        in_ch.func   = FUNC_PRESS;
        in_ch.in_x   = '0;
        in_ch.in_y   = '0;
        in_ch.in_h   = '0;
        in_ch.in_v   = '0;
        out_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // saturated hold counter, stray release, tap, drag, still press, press during drag
        queue_item(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_RELEASE, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_PRESS, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_RELEASE, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_PRESS, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_MOTION, 8'h7F, 8'h80, 8'h80, 8'h7F);
        queue_item(FUNC_MOTION, 8'h80, 8'h7F, 8'h7F, 8'h80);
        queue_item(FUNC_RELEASE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_item(FUNC_PRESS, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_MOTION, 8'd0, 8'd0, 8'd1, 8'hFF);
        queue_item(FUNC_RELEASE, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_PRESS, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_MOTION, 8'd1, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_PRESS, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_RELEASE, 8'd0, 8'd0, 8'd0, 8'd0);
        wait_idle();

        // scroll entry, one-step scrolls both ways, release and exit in scroll mode
        apply_config(2, 0, 0);
        queue_item(FUNC_PRESS, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_MOTION, 8'd1, 8'hFF, 8'd0, 8'd0);
        queue_item(FUNC_RELEASE, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_MOTION, 8'hFF, 8'd1, 8'd0, 8'd0);
        queue_item(FUNC_MOTION, 8'd0, 8'd0, 8'd5, 8'hFB);
        queue_item(FUNC_PRESS, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_item(FUNC_RELEASE, 8'd0, 8'd0, 8'd0, 8'd0);
        wait_idle();

        phase_hold[NUM_PHASES-1] = $urandom_range(1, 30);
        phase_x[NUM_PHASES-1]    = $urandom_range(0, 127);
        phase_y[NUM_PHASES-1]    = $urandom_range(0, 127);
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            apply_config(phase_hold[ph], phase_x[ph], phase_y[ph]);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) queue_gesture();
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
